// ----- rtl/core/lfu_pkg.sv -----
package lfu_pkg;

    localparam int SET_IN_W  = 10;
    localparam int WAY_IN_W  = 4;
    localparam int THR_W     = 4;
    localparam int VICTIM_W  = 4;

    localparam logic [THR_W-1:0] THR_RESET = 4'd15;

    localparam int SETS_DEF         = 1024;
    localparam int WAYS_DEF         = 16;
    localparam int COUNTER_BITS_DEF = 4;

    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

endpackage

// ----- rtl/core/lfu_mem.sv -----
module lfu_mem
    import lfu_pkg::*;
#(
    parameter int DEPTH = SETS_DEF,
    parameter int ROW_W = WAYS_DEF * COUNTER_BITS_DEF,
    parameter int AW    = 10
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [ROW_W-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [ROW_W-1:0] wr_data
);

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/lfu_scan.sv -----
module lfu_scan
    import lfu_pkg::*;
#(
    parameter int WAYS         = WAYS_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF,
    parameter int LV           = $clog2(WAYS)
)
(
    input  logic                         clk,
    input  logic                         load,
    input  logic [WAYS*COUNTER_BITS-1:0] row,
    output logic [LV-1:0]                min_idx,
    output logic [COUNTER_BITS-1:0]      max_val
);

    localparam int P = 1 << LV;
    localparam logic [COUNTER_BITS-1:0] CNT_TOP = {COUNTER_BITS{1'b1}};

    logic [COUNTER_BITS-1:0] mn_v [1:2*P-1];
    logic [LV-1:0]           mn_i [1:2*P-1];
    logic [COUNTER_BITS-1:0] mx_v [1:2*P-1];
    logic [LV-1:0]           min_idx_reg;
    logic [COUNTER_BITS-1:0] max_val_reg;

    // heap-ordered tree; padding leaves never win (ties go to the lower way)
    always_comb
    begin
        for (int i = 0; i < P; i++)
        begin
            if (i < WAYS)
            begin
                mn_v[P+i] = row[i*COUNTER_BITS +: COUNTER_BITS];
                mx_v[P+i] = row[i*COUNTER_BITS +: COUNTER_BITS];
            end
            else
            begin
                mn_v[P+i] = CNT_TOP;
                mx_v[P+i] = '0;
            end
            mn_i[P+i] = LV'(i);
        end
        for (int n = P - 1; n >= 1; n--)
        begin
            if (mn_v[2*n+1] < mn_v[2*n])
            begin
                mn_v[n] = mn_v[2*n+1];
                mn_i[n] = mn_i[2*n+1];
            end
            else
            begin
                mn_v[n] = mn_v[2*n];
                mn_i[n] = mn_i[2*n];
            end
            mx_v[n] = (mx_v[2*n+1] > mx_v[2*n]) ? mx_v[2*n+1] : mx_v[2*n];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            min_idx_reg <= mn_i[1];
            max_val_reg <= mx_v[1];
        end
    end

    assign min_idx = min_idx_reg;
    assign max_val = max_val_reg;

endmodule

// ----- rtl/core/lfu_replacement_with_aging.sv -----
// Per-set LFU replacement with halving aging.
// Request channel: start/busy command handshake; an item is taken at a rising
// edge with start high and busy low. Fields op, set_index, way_index, was_hit.
// op 0 (victim request) gives one result: victim_way with victim_valid high
// for exactly one cycle, in ST_APPLY after the set read and ST_SCAN. op 1
// (access report) gives no result; a miss to a way in range increments that
// way's counter, after halving the whole set if its top counter reached the
// threshold. Each item occupies the block while it issues the set read, scans
// the returned row, then writes back or reports; no new item is taken before
// the last is done. When SETS is below 1024 the set number is first reduced
// in ST_MOD, which lengthens both latency and occupancy.
// cfg_wr_en/cfg_wr_data write aging_threshold; write only while idle.
// Reset: all counters cleared by a sweep through all SETS rows of the memory,
// one row per cycle, with busy high; aging_threshold returns to 15.
// The receiver cannot stall: results must be taken when victim_valid is high.
module lfu_replacement_with_aging
    import lfu_pkg::*;
#(
    parameter int SETS         = SETS_DEF,
    parameter int WAYS         = WAYS_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                op,
    input  logic [SET_IN_W-1:0] set_index,
    input  logic [WAY_IN_W-1:0] way_index,
    input  logic                was_hit,
    output logic                victim_valid,
    output logic [VICTIM_W-1:0] victim_way,
    input  logic                cfg_wr_en,
    input  logic [THR_W-1:0]    cfg_wr_data
);

    localparam int AW       = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int ROW_W    = WAYS * COUNTER_BITS;
    localparam int LV       = $clog2(WAYS);
    localparam int WCW      = (LV + 1 > WAY_IN_W + 1) ? LV + 1 : WAY_IN_W + 1;
    localparam int TW       = (COUNTER_BITS > THR_W) ? COUNTER_BITS : THR_W;
    localparam bit NEED_MOD = (SETS < (1 << SET_IN_W));
    localparam int MODW     = 2 * SET_IN_W + 1;
    localparam int MOD_STEPS = NEED_MOD ? (SET_IN_W - $clog2(SETS) + 1) : 1;
    localparam int SW       = $clog2(SET_IN_W + 2);
    localparam logic [COUNTER_BITS-1:0] CNT_TOP = {COUNTER_BITS{1'b1}};

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_APPLY = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [AW-1:0]           clr_addr_reg, clr_addr_next;
    logic [AW-1:0]           addr_reg, addr_next;
    logic [SET_IN_W-1:0]     rem_reg, rem_next;
    logic [SW-1:0]           step_reg, step_next;
    logic                    op_reg, op_next;
    logic                    fill_reg, fill_next;
    logic [LV-1:0]           way_reg, way_next;
    logic [THR_W-1:0]        thr_reg;

    logic                    accept;
    logic [MODW-1:0]         mod_sub;
    logic [SET_IN_W-1:0]     rem_sub;
    logic                    way_ok;

    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic [ROW_W-1:0]        rd_data;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [ROW_W-1:0]        wr_data;
    logic [ROW_W-1:0]        new_row;
    logic                    halve;

    logic [LV-1:0]           min_idx;
    logic [COUNTER_BITS-1:0] max_val;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign way_ok = (WCW'(way_index) < WCW'(WAYS));

    assign mod_sub = MODW'(SETS) << step_reg;
    assign rem_sub = (MODW'(rem_reg) >= mod_sub) ? SET_IN_W'(MODW'(rem_reg) - mod_sub)
                                                 : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            thr_reg      <= THR_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        op_reg   <= op_next;
        fill_reg <= fill_next;
        way_reg  <= way_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        addr_next     = addr_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        op_next       = op_reg;
        fill_next     = fill_reg;
        way_next      = way_reg;
        rd_en         = 1'b0;
        rd_addr       = addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = op;
                    fill_next = !was_hit && way_ok;
                    way_next  = LV'(WCW'(way_index));
                    if (NEED_MOD)
                    begin
                        rem_next   = set_index;
                        step_next  = SW'(MOD_STEPS - 1);
                        state_next = ST_MOD;
                    end
                    else
                    begin
                        addr_next  = AW'(set_index);
                        rd_en      = 1'b1;
                        rd_addr    = AW'(set_index);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_MOD:
            begin
                rem_next  = rem_sub;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    addr_next  = AW'(rem_sub);
                    rd_en      = 1'b1;
                    rd_addr    = AW'(rem_sub);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign halve = (TW'(max_val) >= TW'(thr_reg));

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            logic [COUNTER_BITS-1:0] c;
            c = rd_data[w*COUNTER_BITS +: COUNTER_BITS];
            if (halve)
            begin
                c = c >> 1;
            end
            if ((LV'(w) == way_reg) && (c != CNT_TOP))
            begin
                c = c + 1'b1;
            end
            new_row[w*COUNTER_BITS +: COUNTER_BITS] = c;
        end
    end

    assign wr_en   = (state_reg == ST_CLEAR) ||
                     ((state_reg == ST_APPLY) && (op_reg == OP_UPDATE) && fill_reg);
    assign wr_addr = (state_reg == ST_CLEAR) ? clr_addr_reg : addr_reg;
    assign wr_data = (state_reg == ST_CLEAR) ? '0 : new_row;

    assign victim_valid = (state_reg == ST_APPLY) && (op_reg == OP_VICTIM);
    assign victim_way   = VICTIM_W'(min_idx);

    lfu_mem #(
        .DEPTH (SETS),
        .ROW_W (ROW_W),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    lfu_scan #(
        .WAYS         (WAYS),
        .COUNTER_BITS (COUNTER_BITS),
        .LV           (LV)
    ) u_scan (
        .clk     (clk),
        .load    (state_reg == ST_SCAN),
        .row     (rd_data),
        .min_idx (min_idx),
        .max_val (max_val)
    );

`ifndef SYNTHESIS
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("row read and write in the same cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    a_victim_range: assert property (@(posedge clk) disable iff (!rst_n)
        victim_valid |-> (WCW'(victim_way) < WCW'(WAYS)))
        else $error("victim way out of range");

    a_victim_single: assert property (@(posedge clk) disable iff (!rst_n)
        victim_valid |=> !victim_valid)
        else $error("victim strobe longer than one cycle");

    a_victim_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        victim_valid |-> ($past(state_reg) == ST_SCAN))
        else $error("victim reported without a scan");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import lfu_pkg::*;

    localparam int          CNT_MAX     = (1 << COUNTER_BITS_DEF) - 1;
    localparam int          N_PROBES    = 23;
    localparam int          N_PHASES    = 6;
    localparam int          PHASE_ITEMS = 175;
    localparam int          DRAIN_WAIT  = 8;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct {
        bit                is_cfg;
        bit                op;
        bit [SET_IN_W-1:0] set_idx;
        bit [WAY_IN_W-1:0] way;
        bit                hit;
        bit [THR_W-1:0]    thr;
        bit                known;
        bit [VICTIM_W-1:0] want;
    } probe_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                op;
    logic [SET_IN_W-1:0] set_index;
    logic [WAY_IN_W-1:0] way_index;
    logic                was_hit;
    logic                victim_valid;
    logic [VICTIM_W-1:0] victim_way;
    logic                cfg_wr_en;
    logic [THR_W-1:0]    cfg_wr_data;

    bit [COUNTER_BITS_DEF-1:0] lfu_counts [SETS_DEF][WAYS_DEF];
    bit [THR_W-1:0]            aging_thr;
    bit [VICTIM_W-1:0]         expected_victims[$];
    int                        mismatches;
    int                        idle_pct;
    int unsigned               cycle_count;
    probe_row_t                probe_rows [N_PROBES];

    lfu_replacement_with_aging dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .set_index    (set_index),
        .way_index    (way_index),
        .was_hit      (was_hit),
        .victim_valid (victim_valid),
        .victim_way   (victim_way),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit [VICTIM_W-1:0] least_used_way(int s);
        int best;
        best = 0;
        for (int w = 1; w < WAYS_DEF; w++)
        begin
            if (lfu_counts[s][w] < lfu_counts[s][best])
                best = w;
        end
        return best[VICTIM_W-1:0];
    endfunction

    function automatic void record_fill(int s, int w);
        int top;
        top = 0;
        for (int i = 0; i < WAYS_DEF; i++)
        begin
            if (lfu_counts[s][i] > top)
                top = lfu_counts[s][i];
        end
        if (top >= aging_thr)
        begin
            for (int i = 0; i < WAYS_DEF; i++)
                lfu_counts[s][i] = lfu_counts[s][i] >> 1;
        end
        if (lfu_counts[s][w] < CNT_MAX)
            lfu_counts[s][w] = lfu_counts[s][w] + 1'b1;
    endfunction

    task automatic note_mismatch(input string what);
        if (mismatches < 10)
            $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // item is accepted at the first edge with start high and busy low
    task automatic issue_item(input bit o, input bit [SET_IN_W-1:0] s,
                              input bit [WAY_IN_W-1:0] w, input bit h,
                              input bit known, input bit [VICTIM_W-1:0] want);
        int s_mod;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start     <= 1'b1;
        op        <= o;
        set_index <= s;
        way_index <= w;
        was_hit   <= h;
        do
            @(posedge clk);
        while (busy);
        s_mod = s % SETS_DEF;
        if (o == OP_VICTIM)
            expected_victims.push_back(known ? want : least_used_way(s_mod));
        else if (!h && w < WAYS_DEF)
            record_fill(s_mod, w);
    endtask

    // threshold written only once the block has gone quiet
    task automatic write_threshold(input bit [THR_W-1:0] v);
        start <= 1'b0;
        while (expected_victims.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        while (busy)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        aging_thr = v;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && victim_valid)
        begin
            if (expected_victims.size() == 0)
                note_mismatch($sformatf("unexpected victim_way %0d", victim_way));
            else
            begin
                bit [VICTIM_W-1:0] exp_way;
                exp_way = expected_victims.pop_front();
                if (victim_way !== exp_way)
                    note_mismatch($sformatf("victim_way exp %0d got %0d",
                                            exp_way, victim_way));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        bit [3:0]          phase_thr [N_PHASES];
        int                phase_idle [N_PHASES];
        bit [SET_IN_W-1:0] hot_set;
        bit                r_op;
        bit                r_hit;
        bit [SET_IN_W-1:0] r_set;
        bit [WAY_IN_W-1:0] r_way;

        phase_thr  = '{4'd1, 4'd15, 4'd0, 4'd8, 4'd3, 4'd15};
        phase_idle = '{38, 38, 65, 65, 0, 0};
        probe_rows = '{
            '{0, OP_VICTIM, 0,    0,  0, 0,  1, 0},
            '{0, OP_VICTIM, 1023, 15, 1, 0,  1, 0},
            '{0, OP_UPDATE, 0,    0,  0, 0,  0, 0},
            '{0, OP_VICTIM, 0,    0,  0, 0,  1, 1},
            '{0, OP_UPDATE, 0,    1,  1, 0,  0, 0},
            '{0, OP_VICTIM, 0,    0,  0, 0,  1, 1},
            '{0, OP_UPDATE, 1023, 15, 0, 0,  0, 0},
            '{0, OP_VICTIM, 1023, 0,  0, 0,  1, 0},
            '{0, OP_UPDATE, 1023, 0,  0, 0,  0, 0},
            '{0, OP_VICTIM, 1023, 0,  0, 0,  1, 1},
            '{1, OP_VICTIM, 0,    0,  0, 1,  0, 0},
            '{0, OP_UPDATE, 7,    3,  0, 0,  0, 0},
            '{0, OP_UPDATE, 7,    3,  0, 0,  0, 0},
            '{0, OP_UPDATE, 7,    0,  0, 0,  0, 0},
            '{0, OP_VICTIM, 7,    0,  0, 0,  0, 0},
            '{1, OP_VICTIM, 0,    0,  0, 0,  0, 0},
            '{0, OP_UPDATE, 9,    2,  0, 0,  0, 0},
            '{0, OP_UPDATE, 9,    2,  0, 0,  0, 0},
            '{0, OP_VICTIM, 9,    0,  0, 0,  0, 0},
            '{0, OP_UPDATE, 682,  5,  0, 0,  0, 0},
            '{0, OP_VICTIM, 341,  10, 1, 0,  0, 0},
            '{0, OP_VICTIM, 682,  0,  0, 0,  0, 0},
            '{1, OP_VICTIM, 0,    0,  0, 15, 0, 0}
        };

        mismatches  = 0;
        idle_pct    = 0;
        aging_thr   = THR_RESET;
        cycle_count <= 0;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        op          <= OP_VICTIM;
        set_index   <= '0;
        way_index   <= '0;
        was_hit     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probe_rows[i])
        begin
            if (probe_rows[i].is_cfg)
                write_threshold(probe_rows[i].thr);
            else
                issue_item(probe_rows[i].op, probe_rows[i].set_idx, probe_rows[i].way,
                           probe_rows[i].hit, probe_rows[i].known, probe_rows[i].want);
        end

        // one hot set per phase, fills biased to two ways so counters climb to the threshold
        for (int p = 0; p < N_PHASES; p++)
        begin
            write_threshold(phase_thr[p]);
            idle_pct = phase_idle[p];
            hot_set  = SET_IN_W'($urandom_range(SETS_DEF - 1));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r_op  = ($urandom_range(99) < 40) ? OP_VICTIM : OP_UPDATE;
                r_hit = ($urandom_range(99) < 15);
                r_set = ($urandom_range(99) < 75) ? hot_set
                                                  : SET_IN_W'($urandom_range(1023));
                r_way = ($urandom_range(99) < 50) ? WAY_IN_W'($urandom_range(1))
                                                  : WAY_IN_W'($urandom_range(15));
                issue_item(r_op, r_set, r_way, r_hit, 1'b0, '0);
            end
        end

        start <= 1'b0;
        while (expected_victims.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && expected_victims.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/lfu_pkg.sv
rtl/core/lfu_mem.sv
rtl/core/lfu_scan.sv
rtl/core/lfu_replacement_with_aging.sv
verif/tb.sv
